// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pfr_pkg.sv =====
// Shared constants, types and codes of the page frame replacement block.
package pfr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;

	localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int LEAVES  = 1 << FRAME_W;
	localparam int RANK_W  = FRAME_W;
	localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
	localparam int FIU_W   = 5;
	localparam int ACT_W   = (CNT_W > FIU_W) ? CNT_W : FIU_W;
	localparam int FAULT_W = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_POLICY = 2'd0;
	localparam cfg_idx_t REG_FRAMES = 2'd1;

	localparam logic [FIU_W-1:0] RESET_FRAMES = 5'd16;

	typedef enum logic {
		POL_FIFO = 1'b0,
		POL_LRU  = 1'b1
	} policy_t;

	typedef logic [FRAME_W-1:0]   frame_idx_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [ACT_W-1:0]     count_t;
	typedef logic [FAULT_W-1:0]   fault_t;

	typedef page_t [MAX_FRAMES-1:0]  page_vec_t;
	typedef rank_t [MAX_FRAMES-1:0]  rank_vec_t;
	typedef logic [MAX_FRAMES-1:0]   flag_vec_t;

	localparam rank_t RANK_MAX = rank_t'(MAX_FRAMES - 1);

	// Outcome of one lookup in the frame table.
	typedef struct packed {
		logic       hit;
		logic       load_free;
		logic       evict;
		logic       fill_adv;
		frame_idx_t frame;
		page_t      evicted_page;
	} pfr_decision_t;

	// Word held in the input stage, with the strobe that commits it.
	typedef struct packed {
		logic  commit;
		logic  last;
		page_t page;
	} pfr_cmd_t;

endpackage

// ===== rtl/core/pfr_if.sv =====
// Valid/ready channels carrying reference words in and result words out.
interface pfr_in_if;
	logic                     valid;
	logic                     ready;
	logic [pfr_pkg::PAGE_BITS-1:0] page_number;
	logic                     end_of_string;

	modport source(output valid, page_number, end_of_string, input ready);
	modport sink(input valid, page_number, end_of_string, output ready);
endinterface

interface pfr_out_if;
	logic                         valid;
	logic                         ready;
	logic                         page_fault;
	logic [pfr_pkg::FRAME_W-1:0]  frame_index;
	logic                         evicted_valid;
	logic [pfr_pkg::PAGE_BITS-1:0] evicted_page;
	logic [pfr_pkg::FAULT_W-1:0]  fault_total;

	modport source(output valid, page_fault, frame_index, evicted_valid, evicted_page,
		fault_total, input ready);
	modport sink(input valid, page_fault, frame_index, evicted_valid, evicted_page,
		fault_total, output ready);
endinterface

// ===== rtl/core/pfr_select.sv =====
// Parallel lookup of the frame table: hit, free frame and victim selection.
module pfr_select (
	input  pfr_pkg::page_t         page,
	input  pfr_pkg::page_vec_t     frame_page,
	input  pfr_pkg::flag_vec_t     frame_valid,
	input  pfr_pkg::rank_vec_t     frame_rank,
	input  pfr_pkg::flag_vec_t     active,
	input  pfr_pkg::frame_idx_t    fill_ptr,
	input  pfr_pkg::policy_t       policy,
	output pfr_pkg::pfr_decision_t dec
);

	logic                hit;
	pfr_pkg::frame_idx_t hit_idx;
	logic                any_free;
	pfr_pkg::frame_idx_t free_idx;
	pfr_pkg::frame_idx_t lru_idx;
	logic                evict;
	pfr_pkg::frame_idx_t frame;

	logic                tree_ok  [2*pfr_pkg::LEAVES];
	pfr_pkg::rank_t      tree_rank[2*pfr_pkg::LEAVES];
	pfr_pkg::frame_idx_t tree_idx [2*pfr_pkg::LEAVES];

	// Lowest matching frame wins; a free frame at the fill pointer is taken first, else the lowest free one.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		any_free = 1'b0;
		free_idx = '0;
		for (int i = pfr_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
			if (active[i] && frame_valid[i] && frame_page[i] == page) begin
				hit     = 1'b1;
				hit_idx = pfr_pkg::frame_idx_t'(i);
			end
			if (active[i] && !frame_valid[i]) begin
				any_free = 1'b1;
				free_idx = pfr_pkg::frame_idx_t'(i);
			end
		end
		if (!frame_valid[fill_ptr]) begin
			free_idx = fill_ptr;
		end
	end

	// Oldest rank by a binary tree; on a tie the lower frame is kept.
	always_comb begin
		for (int k = 0; k < 2 * pfr_pkg::LEAVES; k++) begin
			tree_ok[k]   = 1'b0;
			tree_rank[k] = '0;
			tree_idx[k]  = '0;
		end
		for (int i = 0; i < pfr_pkg::LEAVES; i++) begin
			if (i < pfr_pkg::MAX_FRAMES) begin
				tree_ok[pfr_pkg::LEAVES + i]   = active[i];
				tree_rank[pfr_pkg::LEAVES + i] = frame_rank[i];
			end
			tree_idx[pfr_pkg::LEAVES + i] = pfr_pkg::frame_idx_t'(i);
		end
		for (int k = pfr_pkg::LEAVES - 1; k >= 1; k--) begin
			if (tree_ok[2*k+1] && (!tree_ok[2*k] || tree_rank[2*k+1] > tree_rank[2*k])) begin
				tree_ok[k]   = 1'b1;
				tree_rank[k] = tree_rank[2*k+1];
				tree_idx[k]  = tree_idx[2*k+1];
			end else begin
				tree_ok[k]   = tree_ok[2*k];
				tree_rank[k] = tree_rank[2*k];
				tree_idx[k]  = tree_idx[2*k];
			end
		end
		lru_idx = tree_idx[1];
	end

	always_comb begin
		evict = !hit && !any_free;
		if (hit) begin
			frame = hit_idx;
		end else if (any_free) begin
			frame = free_idx;
		end else if (policy == pfr_pkg::POL_FIFO) begin
			frame = fill_ptr;
		end else begin
			frame = lru_idx;
		end
		dec.hit          = hit;
		dec.load_free    = !hit && any_free;
		dec.evict        = evict;
		dec.fill_adv     = !hit && (any_free || policy == pfr_pkg::POL_FIFO);
		dec.frame        = frame;
		dec.evicted_page = evict ? frame_page[frame] : '0;
	end

endmodule

// ===== rtl/core/pfr_table.sv =====
// Frame table state: pages, valid bits, recency ranks, fill pointer and fault count.
module pfr_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfr_pkg::flag_vec_t     active,
	input  pfr_pkg::count_t        act_n,
	input  pfr_pkg::pfr_cmd_t      cmd,
	input  pfr_pkg::pfr_decision_t dec,
	output pfr_pkg::page_vec_t     frame_page,
	output pfr_pkg::flag_vec_t     frame_valid,
	output pfr_pkg::rank_vec_t     frame_rank,
	output pfr_pkg::frame_idx_t    fill_ptr,
	output pfr_pkg::fault_t        fault_total
);

	pfr_pkg::page_vec_t  page_q;
	pfr_pkg::flag_vec_t  valid_q;
	pfr_pkg::rank_vec_t  rank_q;
	pfr_pkg::frame_idx_t fill_q;
	pfr_pkg::fault_t     fault_q;

	pfr_pkg::flag_vec_t  valid_d;
	pfr_pkg::rank_vec_t  rank_d;
	pfr_pkg::frame_idx_t fill_eff;
	pfr_pkg::frame_idx_t fill_d;
	pfr_pkg::count_t     next_cnt;
	pfr_pkg::rank_t      old_rank;
	logic                was_valid;

	// A pointer left beyond a shrunken frame count restarts at frame zero.
	assign fill_eff = (pfr_pkg::count_t'(fill_q) >= act_n) ? '0 : fill_q;
	assign next_cnt = pfr_pkg::count_t'(dec.frame) + pfr_pkg::count_t'(1);

	always_comb begin
		fill_d = fill_eff;
		if (dec.fill_adv) begin
			fill_d = (next_cnt == act_n) ? '0 : pfr_pkg::frame_idx_t'(next_cnt);
		end
	end

	always_comb begin
		valid_d = valid_q;
		if (!dec.hit) begin
			valid_d[dec.frame] = 1'b1;
		end
	end

	// The touched frame becomes the youngest; on a fresh load every other
	// valid frame ages, otherwise only those younger than it did.
	always_comb begin
		old_rank  = rank_q[dec.frame];
		was_valid = !dec.load_free;
		for (int i = 0; i < pfr_pkg::MAX_FRAMES; i++) begin
			rank_d[i] = rank_q[i];
			if (pfr_pkg::frame_idx_t'(i) == dec.frame) begin
				rank_d[i] = '0;
			end else if (active[i] && valid_q[i] && (!was_valid || rank_q[i] < old_rank)
				&& rank_q[i] != pfr_pkg::RANK_MAX) begin
				rank_d[i] = rank_q[i] + 1'b1;
			end
		end
	end

	assign fault_total = (!dec.hit && fault_q != '1) ? fault_q + 1'b1 : fault_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && !dec.hit) begin
			page_q[dec.frame] <= cmd.page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
			fill_q  <= '0;
			fault_q <= '0;
		end else if (cmd.commit) begin
			if (cmd.last) begin
				valid_q <= '0;
				rank_q  <= '0;
				fill_q  <= '0;
				fault_q <= '0;
			end else begin
				valid_q <= valid_d;
				rank_q  <= rank_d;
				fill_q  <= fill_d;
				fault_q <= fault_total;
			end
		end
	end

	assign frame_page  = page_q;
	assign frame_valid = valid_q;
	assign frame_rank  = rank_q;
	assign fill_ptr    = fill_eff;

endmodule

// ===== rtl/core/page_frame_replacement.sv =====
// Page frame replacement table (FIFO or LRU) with valid/ready channels.
// Each reference word yields exactly one result word, registered in the input
// stage and then the result register, and one word can be accepted in every
// clock cycle unless the output stalls: the whole frame table (MAX_FRAMES
// pages, valid bits and recency ranks in flip-flops) is searched and updated
// as a word moves from the input stage to the result register, which sets the
// rate. The table starts empty after reset with no clearing pass, and a word
// with end_of_string set clears it, and the fault total, after its result.
// Policy and frame count are to be written through the configuration port
// only while the block is idle, which the block does not enforce; a frame
// count of zero acts as one and one above MAX_FRAMES as MAX_FRAMES.
module page_frame_replacement (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	pfr_in_if.sink                           in,
	pfr_out_if.source                        out
);

	pfr_pkg::policy_t           policy_q;
	logic [pfr_pkg::FIU_W-1:0]  frames_q;

	logic                       valid_s1;
	pfr_pkg::page_t             page_s1;
	logic                       last_s1;

	logic                       valid_s2;
	logic                       fault_s2;
	pfr_pkg::frame_idx_t        frame_s2;
	logic                       evicted_s2;
	pfr_pkg::page_t             evicted_page_s2;
	pfr_pkg::fault_t            total_s2;

	logic                       advance;
	pfr_pkg::count_t            act_n;
	pfr_pkg::flag_vec_t         active;
	pfr_pkg::pfr_cmd_t          cmd;
	pfr_pkg::pfr_decision_t     dec;
	pfr_pkg::page_vec_t         frame_page;
	pfr_pkg::flag_vec_t         frame_valid;
	pfr_pkg::rank_vec_t         frame_rank;
	pfr_pkg::frame_idx_t        fill_ptr;
	pfr_pkg::fault_t            fault_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfr_pkg::POL_FIFO;
			frames_q <= pfr_pkg::RESET_FRAMES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfr_pkg::REG_POLICY: policy_q <= pfr_pkg::policy_t'(cfg_data[0]);
				pfr_pkg::REG_FRAMES: frames_q <= cfg_data[pfr_pkg::FIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frames_q == '0) begin
			act_n = pfr_pkg::count_t'(1);
		end else if (pfr_pkg::count_t'(frames_q) > pfr_pkg::count_t'(pfr_pkg::MAX_FRAMES)) begin
			act_n = pfr_pkg::count_t'(pfr_pkg::MAX_FRAMES);
		end else begin
			act_n = pfr_pkg::count_t'(frames_q);
		end
		for (int i = 0; i < pfr_pkg::MAX_FRAMES; i++) begin
			active[i] = pfr_pkg::count_t'(i) < act_n;
		end
	end

	// The input stage moves on whenever the result register is empty or drained.
	assign advance  = valid_s1 && (!valid_s2 || out.ready);
	assign in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			page_s1 <= in.page_number;
			last_s1 <= in.end_of_string;
		end
	end

	assign cmd.commit = advance;
	assign cmd.last   = last_s1;
	assign cmd.page   = page_s1;

	pfr_select u_select (
		.page        (page_s1),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.frame_rank  (frame_rank),
		.active      (active),
		.fill_ptr    (fill_ptr),
		.policy      (policy_q),
		.dec         (dec)
	);

	pfr_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.active      (active),
		.act_n       (act_n),
		.cmd         (cmd),
		.dec         (dec),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.frame_rank  (frame_rank),
		.fill_ptr    (fill_ptr),
		.fault_total (fault_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fault_s2        <= !dec.hit;
			frame_s2        <= dec.frame;
			evicted_s2      <= dec.evict;
			evicted_page_s2 <= dec.evicted_page;
			total_s2        <= fault_total;
		end
	end

	assign out.valid         = valid_s2;
	assign out.page_fault    = fault_s2;
	assign out.frame_index   = frame_s2;
	assign out.evicted_valid = evicted_s2;
	assign out.evicted_page  = evicted_page_s2;
	assign out.fault_total   = total_s2;

endmodule

// ===== rtl/core/pfr_checker.sv =====
// Port-level checks on the page frame replacement block, bound to its top level.
`include "assert_macros.svh"

module pfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          page_fault,
	input logic [pfr_pkg::FRAME_W-1:0]   frame_index,
	input logic                          evicted_valid,
	input logic [pfr_pkg::PAGE_BITS-1:0] evicted_page,
	input logic [pfr_pkg::FAULT_W-1:0]   fault_total
);

	logic                                                           stalled;
	logic                                                           evict_seen;
	logic                                                           no_evict;
	logic                                                           fault_seen;
	logic [pfr_pkg::FRAME_W+pfr_pkg::PAGE_BITS+pfr_pkg::FAULT_W+1:0] res_word;

	assign stalled    = out_valid && !out_ready;
	assign evict_seen = out_valid && evicted_valid;
	assign no_evict   = out_valid && !evicted_valid;
	assign fault_seen = out_valid && page_fault;
	assign res_word   = {page_fault, frame_index, evicted_valid, evicted_page, fault_total};

	// A stalled result word must not change.
	`PFR_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(res_word), "word not held")

	// Only a fault can replace a resident page.
	`PFR_ASSERT_SAME(a_evict_fault, clk, arst_n, evict_seen, page_fault, "eviction on a hit")

	`PFR_ASSERT_SAME(a_evict_zero, clk, arst_n, no_evict, evicted_page == '0, "evicted page not zero")

	// A faulting word is counted in its own total.
	`PFR_ASSERT_SAME(a_fault_count, clk, arst_n, fault_seen, fault_total != '0, "fault not counted")

endmodule

bind page_frame_replacement pfr_checker u_pfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out.valid),
	.out_ready     (out.ready),
	.page_fault    (out.page_fault),
	.frame_index   (out.frame_index),
	.evicted_valid (out.evicted_valid),
	.evicted_page  (out.evicted_page),
	.fault_total   (out.fault_total)
);

// ===== verif/page_frame_replacement_test.sv =====
// Self-checking testbench for the page frame replacement block.
module page_frame_replacement_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 200;
	localparam int unsigned PHASE_WORDS = 94;
	localparam pfr_pkg::cfg_idx_t REG_SPARE_LO = 2'd2;
	localparam pfr_pkg::cfg_idx_t REG_SPARE_HI = 2'd3;
	localparam logic [pfr_pkg::FIU_W-1:0] FRAME_PICKS [8] =
		'{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd2};

	typedef struct packed {
		pfr_pkg::page_t page;
		logic           last;
	} ref_word_t;

	typedef struct packed {
		logic                fault;
		pfr_pkg::frame_idx_t frame;
		logic                evicted;
		pfr_pkg::page_t      evicted_page;
		pfr_pkg::fault_t     total;
	} pfr_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	pfr_pkg::cfg_idx_t cfg_index;
	logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data;

	pfr_in_if  ref_ch();
	pfr_out_if res_ch();

	page_frame_replacement DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in(ref_ch),
		.out(res_ch)
	);

	// Shadow copy of the frame table and its settings.
	pfr_pkg::policy_t          mode_policy;
	logic [pfr_pkg::FIU_W-1:0] mode_frames;
	pfr_pkg::page_t            tbl_page [pfr_pkg::MAX_FRAMES] = '{default: '0};
	logic                      tbl_valid [pfr_pkg::MAX_FRAMES] = '{default: 1'b0};
	pfr_pkg::rank_t            tbl_rank [pfr_pkg::MAX_FRAMES] = '{default: '0};
	int unsigned               fill_ptr = 0;
	pfr_pkg::fault_t           fault_cnt = '0;

	ref_word_t   pending_words [$];
	pfr_result_t expected_results [$];
	ref_word_t   next_word;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	logic        no_gaps;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void clear_table();
		foreach (tbl_page[i]) begin
			tbl_page[i]  = '0;
			tbl_valid[i] = 1'b0;
			tbl_rank[i]  = '0;
		end
		fill_ptr  = 0;
		fault_cnt = '0;
	endfunction

	// Frame f becomes youngest; younger ones (all on a free load) age, saturating.
	function automatic void promote_frame(int unsigned f, int unsigned n, logic was_valid);
		pfr_pkg::rank_t old;
		int unsigned i;
		old = tbl_rank[f];
		for (i = 0; i < n; i++) begin
			if (i != f && tbl_valid[i] && (!was_valid || tbl_rank[i] < old) &&
					tbl_rank[i] < pfr_pkg::RANK_MAX)
				tbl_rank[i]++;
		end
		tbl_rank[f] = '0;
	endfunction

	function automatic pfr_result_t predict_reference(pfr_pkg::page_t page, logic last);
		pfr_result_t res;
		int unsigned n, f, i;
		logic hit, free_found;
		pfr_pkg::rank_t oldest;
		res = '0;
		hit = 1'b0;
		free_found = 1'b0;
		f = 0;
		n = (mode_frames == 0) ? 1 :
			((mode_frames > pfr_pkg::MAX_FRAMES) ? pfr_pkg::MAX_FRAMES : mode_frames);
		for (i = 0; i < n; i++) begin
			if (!hit && tbl_valid[i] && tbl_page[i] == page) begin
				hit = 1'b1;
				f = i;
			end
		end
		if (fill_ptr >= n)
			fill_ptr = 0;
		if (hit) begin
			promote_frame(f, n, 1'b1);
		end else begin
			if (!tbl_valid[fill_ptr]) begin
				f = fill_ptr;
				free_found = 1'b1;
			end else begin
				for (i = 0; i < n; i++) begin
					if (!free_found && !tbl_valid[i]) begin
						f = i;
						free_found = 1'b1;
					end
				end
			end
			if (free_found || mode_policy == pfr_pkg::POL_FIFO) begin
				if (!free_found)
					f = fill_ptr;
				fill_ptr = (f + 1) % n;
			end else begin
				oldest = tbl_rank[0];
				f = 0;
				for (i = 1; i < n; i++) begin
					if (tbl_rank[i] > oldest) begin
						oldest = tbl_rank[i];
						f = i;
					end
				end
			end
			if (!free_found) begin
				res.evicted = 1'b1;
				res.evicted_page = tbl_page[f];
			end
			promote_frame(f, n, !free_found);
			tbl_page[f] = page;
			tbl_valid[f] = 1'b1;
			if (fault_cnt != '1)
				fault_cnt++;
		end
		res.fault = !hit;
		res.frame = pfr_pkg::frame_idx_t'(f);
		res.total = fault_cnt;
		if (last)
			clear_table();
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Sender: offers queued words, holding each until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			ref_ch.valid <= 1'b0;
		end else begin
			if (ref_ch.valid && ref_ch.ready)
				expected_results.push_back(
					predict_reference(ref_ch.page_number, ref_ch.end_of_string));
			if (!(ref_ch.valid && !ref_ch.ready)) begin
				if (send_gap != 0) begin
					send_gap--;
					ref_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					ref_ch.valid <= 1'b1;
					ref_ch.page_number <= next_word.page;
					ref_ch.end_of_string <= next_word.last;
					send_gap = pick_gap();
				end else begin
					ref_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word and stalls at random, twice for a long stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result word arrived with nothing expected");
					mismatch_count++;
				end else begin
					pfr_result_t want;
					want = expected_results.pop_front();
					check_field("page_fault", 32'(want.fault), 32'(res_ch.page_fault));
					check_field("frame_index", 32'(want.frame), 32'(res_ch.frame_index));
					check_field("evicted_valid", 32'(want.evicted),
						32'(res_ch.evicted_valid));
					check_field("evicted_page", 32'(want.evicted_page),
						32'(res_ch.evicted_page));
					check_field("fault_total", want.total, res_ch.fault_total);
				end
				results_seen++;
				if (results_seen == 150 || results_seen == 520)
					recv_stall = LONG_HOLD;
				else
					recv_stall = pick_gap();
			end
			if (recv_stall != 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_word(pfr_pkg::page_t page, logic last);
		ref_word_t w;
		w.page = page;
		w.last = last;
		pending_words.push_back(w);
	endtask

	// Sampled away from the rising edge so that every update of that edge has settled.
	task automatic wait_idle();
		while (pending_words.size() != 0 || ref_ch.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(pfr_pkg::cfg_idx_t idx, logic [pfr_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pfr_pkg::REG_POLICY: mode_policy = pfr_pkg::policy_t'(data[0]);
			pfr_pkg::REG_FRAMES: mode_frames = data;
			default: ;
		endcase
	endtask

	initial begin
		int unsigned phase, item, span, ws;
		pfr_pkg::page_t base, pg;
		logic last;
		logic [pfr_pkg::FIU_W-1:0] frames_pick;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pfr_pkg::REG_POLICY;
		cfg_data = '0;
		no_gaps = 1'b0;
		mode_policy = pfr_pkg::POL_FIFO;
		mode_frames = pfr_pkg::RESET_FRAMES;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extremes of the page field, a hit, then end of string.
		queue_word(16'h0000, 1'b0);
		queue_word(16'hFFFF, 1'b0);
		queue_word(16'h0000, 1'b0);
		queue_word(16'h5A5A, 1'b1);
		wait_idle();

		// Three frames, first in first out: fill, hit, three evictions.
		write_register(pfr_pkg::REG_FRAMES, 5'd3);
		queue_word(16'd1, 1'b0);
		queue_word(16'd2, 1'b0);
		queue_word(16'd3, 1'b0);
		queue_word(16'd1, 1'b0);
		queue_word(16'd4, 1'b0);
		queue_word(16'd1, 1'b0);
		queue_word(16'd5, 1'b1);
		wait_idle();

		// A similar sequence under least recently used, with page 3 where page 1 recurred.
		write_register(pfr_pkg::REG_POLICY, {4'b1010, pfr_pkg::POL_LRU});
		queue_word(16'd1, 1'b0);
		queue_word(16'd2, 1'b0);
		queue_word(16'd3, 1'b0);
		queue_word(16'd1, 1'b0);
		queue_word(16'd4, 1'b0);
		queue_word(16'd3, 1'b0);
		queue_word(16'd5, 1'b1);
		wait_idle();

		// Shrinking the table mid-string leaves the fill pointer out of range and
		// lets a page be loaded twice; growing it again exposes the duplicate and
		// a free frame away from the fill pointer.
		write_register(pfr_pkg::REG_POLICY, {4'b0101, pfr_pkg::POL_FIFO});
		write_register(pfr_pkg::REG_FRAMES, 5'd4);
		queue_word(16'd10, 1'b0);
		queue_word(16'd11, 1'b0);
		queue_word(16'd12, 1'b0);
		wait_idle();
		write_register(pfr_pkg::REG_FRAMES, 5'd2);
		queue_word(16'd12, 1'b0);
		wait_idle();
		write_register(pfr_pkg::REG_FRAMES, 5'd4);
		queue_word(16'd12, 1'b0);
		queue_word(16'd99, 1'b0);
		queue_word(16'd7, 1'b1);

		for (phase = 0; phase < 8; phase++) begin
			wait_idle();
			no_gaps = (phase == 5);
			if (phase == 2) begin
				write_register(REG_SPARE_LO, 5'($urandom));
				write_register(REG_SPARE_HI, 5'($urandom));
			end
			write_register(pfr_pkg::REG_POLICY, {4'($urandom), 1'(phase[0] ^ phase[2])});
			frames_pick = (phase == 7) ? 5'($urandom_range(1, 16)) : FRAME_PICKS[phase];
			write_register(pfr_pkg::REG_FRAMES, frames_pick);
			span = (frames_pick == 0) ? 1 :
				((frames_pick > pfr_pkg::MAX_FRAMES) ? pfr_pkg::MAX_FRAMES : frames_pick);
			ws = $urandom_range(span, 2 * span + 1);
			base = pfr_pkg::page_t'($urandom);
			// Mostly references from a small working set so that hits and
			// evictions both occur, with some scattered pages as noise.
			for (item = 0; item < PHASE_WORDS; item++) begin
				if ($urandom_range(0, 9) == 0)
					pg = pfr_pkg::page_t'($urandom);
				else
					pg = base + pfr_pkg::page_t'($urandom_range(0, ws - 1));
				last = ($urandom_range(0, 49) == 0) ||
					(item == PHASE_WORDS - 1 && phase[0]);
				queue_word(pg, last);
				if (last) begin
					ws = $urandom_range(span, 2 * span + 1);
					base = pfr_pkg::page_t'($urandom);
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pfr_pkg.sv
rtl/core/pfr_if.sv
rtl/core/pfr_select.sv
rtl/core/pfr_table.sv
rtl/core/page_frame_replacement.sv
rtl/core/pfr_checker.sv
verif/page_frame_replacement_test.sv
